// ===== hw/rtl/pbp_pkg.sv =====
// ----------------------------------------------------------------------------
// pbp_pkg
// Shared types and constants of the perceptron branch predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package pbp_pkg;

	localparam int ADDR_W   = 64;
	localparam int WGT_W    = 9;    // signed weight width
	localparam int SUM_W    = 16;   // signed perceptron output width
	localparam int PEN_W    = 8;
	localparam int THR_W    = 13;
	localparam int CFG_W    = 13;   // widest register
	localparam int GRP      = 8;    // weights added per group in the first sum stage
	localparam int OUT_W    = 16;   // result beat, padded to bytes

	localparam logic signed [WGT_W:0] WGT_MAX = 10'sd255;
	localparam logic signed [WGT_W:0] WGT_MIN = -10'sd256;

	typedef enum logic {
		REQ_PREDICT = 1'b0,
		REQ_RESOLVE = 1'b1
	} kind_t;

	typedef enum logic {
		CFG_MISS_PENALTY = 1'b0,
		CFG_THRESHOLD    = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		kind_t              kind;
		logic [ADDR_W-1:0]  address;
		logic [ADDR_W-1:0]  fallthrough;
	} req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_P_WAIT,
		ST_P_SUM,
		ST_R_EVAL,
		ST_OUT
	} bst_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pbp_ram.sv =====
// ----------------------------------------------------------------------------
// pbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_ram #(
	parameter int W  = 8,
	parameter int D  = 16,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pbp_front.sv =====
// ----------------------------------------------------------------------------
// pbp_front
// Input side: takes request beats, finds the weight row and queues requests.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_front #(
	parameter int ROWS = 256,
	localparam int RB  = $clog2(ROWS)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire pbp_pkg::req_t          in_req,
	output logic                        q_valid,
	output pbp_pkg::req_t               q_req,
	output logic [RB-1:0]               q_row,
	input  wire logic                   q_pop
);
	import pbp_pkg::*;

	localparam bit POW2  = (ROWS & (ROWS - 1)) == 0;
	localparam int QD    = 2;
	localparam int CH    = 16;                  // address bits folded per step
	localparam int VW    = RB + CH;             // partial remainder with next chunk
	localparam logic [VW-1:0] MREC = VW'((64'd1 << VW) / 64'(ROWS));
	localparam logic [6:0] NSTEP = 7'(2 * ADDR_W / CH);

	logic              hold_q;
	req_t              hold_req_q;
	logic [RB-1:0]     rem_q;
	logic [ADDR_W-1:0] sh_q;
	logic [6:0]        cnt_q;
	logic [VW-1:0]     v_c, v_q;
	logic [2*VW-1:0]   prod_c;
	logic [CH-1:0]     qest_q;
	logic [VW:0]       qr_c, diff_c;
	logic [RB-1:0]     rem_c;
	logic [RB-1:0]     row_c;
	logic              push;

	req_t              qreq_q [QD];
	logic [RB-1:0]     qrow_q [QD];
	logic              wp_q, rp_q;
	logic [1:0]        fill_q;

	assign in_ready = !hold_q;

	// reduce each 16-bit address chunk in turn when ROWS is not a power of two:
	// estimate the quotient by a reciprocal multiply, then subtract and correct
	always_comb begin
		v_c    = {rem_q, sh_q[ADDR_W-1 -: CH]};
		prod_c = (2*VW)'(v_c) * (2*VW)'(MREC);
		qr_c   = (VW+1)'(qest_q) * (VW+1)'(ROWS);
		diff_c = {1'b0, v_q} - qr_c;
		if (diff_c >= (VW+1)'(ROWS)) begin
			diff_c = diff_c - (VW+1)'(ROWS);
		end
		rem_c = diff_c[RB-1:0];
	end

	assign row_c = POW2 ? hold_req_q.address[RB-1:0] : rem_q;
	assign push  = hold_q && (cnt_q == 7'd0) && (fill_q != 2'(QD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				hold_q <= 1'b1;
				cnt_q  <= (POW2 || in_req.kind == REQ_RESOLVE) ? 7'd0 : NSTEP;
			end else begin
				if (push) begin
					hold_q <= 1'b0;
				end
				if (cnt_q != 7'd0) begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hold_req_q <= in_req;
			rem_q      <= '0;
			sh_q       <= in_req.address;
		end else if (cnt_q != 7'd0) begin
			if (cnt_q[0]) begin
				rem_q <= rem_c;
				sh_q  <= {sh_q[ADDR_W-CH-1:0], CH'(0)};
			end else begin
				v_q    <= v_c;
				qest_q <= prod_c[VW +: CH];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (q_pop) begin
				rp_q <= !rp_q;
			end
			case ({push, q_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			qreq_q[wp_q] <= hold_req_q;
			qrow_q[wp_q] <= row_c;
		end
	end

	assign q_valid = (fill_q != 2'd0);
	assign q_req   = qreq_q[rp_q];
	assign q_row   = qrow_q[rp_q];

endmodule

`default_nettype wire

// ===== hw/rtl/pbp_back.sv =====
// ----------------------------------------------------------------------------
// pbp_back
// Execution side: weight store, perceptron sum, training and result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_back #(
	parameter int ROWS       = 256,
	parameter int HIST_SLOTS = 32,
	localparam int RB        = $clog2(ROWS)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	input  wire pbp_pkg::req_t               q_req,
	input  wire logic [RB-1:0]               q_row,
	output logic                             q_pop,
	input  wire logic [pbp_pkg::PEN_W-1:0]   miss_penalty,
	input  wire logic [pbp_pkg::THR_W-1:0]   threshold,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [pbp_pkg::OUT_W-1:0]        m_tdata
);
	import pbp_pkg::*;

	localparam int ROW_W = HIST_SLOTS * WGT_W;
	localparam int NG    = (HIST_SLOTS + GRP - 1) / GRP;

	bst_t state_q, state_d;

	// RAM port
	logic             ram_we;
	logic [RB-1:0]    ram_waddr, ram_raddr;
	logic [ROW_W-1:0] ram_wdata, ram_rdata;

	logic [RB-1:0]    clr_q;
	logic             clr_last;

	// history slot 0 stands for the constant bias input
	logic signed [1:0] hist_q [1:HIST_SLOTS-1];
	logic signed [1:0] xv [HIST_SLOTS];

	logic                     pend_valid_q, pend_dir_q;
	logic [RB-1:0]            pend_row_q;
	logic signed [SUM_W-1:0]  pend_sum_q;
	logic [ADDR_W-1:0]        pend_ft_q;
	logic [PEN_W-1:0]         cur_pen_q;

	kind_t                    cur_kind_q;
	logic [ADDR_W-1:0]        cur_addr_q;
	logic [ADDR_W-1:0]        cur_ft_q;
	logic [RB-1:0]            cur_row_q;

	logic signed [SUM_W-1:0]  grp_s1 [NG];
	logic signed [SUM_W-1:0]  sum_c;

	logic                     res_taken_q, res_miss_q;
	logic                     m_valid_q;
	logic [OUT_W-1:0]         m_data_q;

	logic                     outcome, miss, do_train;
	logic signed [SUM_W-1:0]  mag;
	logic signed [1:0]        t_c;
	logic [ROW_W-1:0]         trained;
	logic                     out_free;

	pbp_ram #(.W(ROW_W), .D(ROWS)) u_wram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign clr_last = (clr_q == RB'(ROWS - 1));
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		xv[0] = 2'sb01;
		for (int i = 1; i < HIST_SLOTS; i++) begin
			xv[i] = hist_q[i];
		end
	end

	// first sum stage: groups of weights times history inputs
	always_ff @(posedge clk) begin
		if (state_q == ST_P_WAIT) begin
			for (int g = 0; g < NG; g++) begin
				logic signed [SUM_W-1:0] acc;
				logic signed [SUM_W-1:0] w;
				acc = '0;
				for (int j = 0; j < GRP; j++) begin
					if (g * GRP + j < HIST_SLOTS) begin
						w = SUM_W'($signed(ram_rdata[(g*GRP+j)*WGT_W +: WGT_W]));
						if (xv[g*GRP+j] == 2'sb01) begin
							acc = acc + w;
						end else if (xv[g*GRP+j] == 2'sb11) begin
							acc = acc - w;
						end
					end
				end
				grp_s1[g] <= acc;
			end
		end
	end

	always_comb begin
		sum_c = '0;
		for (int g = 0; g < NG; g++) begin
			sum_c = sum_c + grp_s1[g];
		end
	end

	// resolve evaluation against the pending branch
	assign outcome  = (cur_addr_q != pend_ft_q);
	assign t_c      = outcome ? 2'sb01 : 2'sb11;
	assign miss     = (outcome != pend_dir_q);
	assign mag      = pend_sum_q[SUM_W-1] ? -pend_sum_q : pend_sum_q;
	assign do_train = miss || (mag <= $signed({3'b000, threshold}));

	always_comb begin
		for (int i = 0; i < HIST_SLOTS; i++) begin
			logic signed [WGT_W:0] n;
			logic signed [WGT_W:0] wx;
			wx = (WGT_W+1)'($signed(ram_rdata[i*WGT_W +: WGT_W]));
			if (xv[i] == 2'sb01) begin
				n = wx + (WGT_W+1)'(t_c);
			end else if (xv[i] == 2'sb11) begin
				n = wx - (WGT_W+1)'(t_c);
			end else begin
				n = wx;
			end
			if (n <= WGT_MAX && n >= WGT_MIN) begin
				trained[i*WGT_W +: WGT_W] = n[WGT_W-1:0];
			end else begin
				trained[i*WGT_W +: WGT_W] = ram_rdata[i*WGT_W +: WGT_W];
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (q_valid) state_d = (q_req.kind == REQ_PREDICT) ? ST_P_WAIT : ST_R_EVAL;
			end
			ST_P_WAIT: state_d = ST_P_SUM;
			ST_P_SUM:  state_d = ST_OUT;
			ST_R_EVAL: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cur_row_q;
		ram_wdata = trained;
		ram_raddr = pend_row_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				q_pop     = q_valid;
				ram_raddr = (q_req.kind == REQ_PREDICT) ? q_row : pend_row_q;
			end
			ST_R_EVAL: begin
				ram_waddr = pend_row_q;
				ram_we    = pend_valid_q && (pend_ft_q != '0) && do_train;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_dir_q   <= 1'b0;
			pend_row_q   <= '0;
			pend_sum_q   <= '0;
			pend_ft_q    <= '0;
			cur_pen_q    <= '0;
			m_valid_q    <= 1'b0;
			for (int i = 1; i < HIST_SLOTS; i++) hist_q[i] <= 2'sb00;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + RB'(1);
			end
			if (state_q == ST_P_SUM) begin
				pend_valid_q <= 1'b1;
				pend_row_q   <= cur_row_q;
				pend_dir_q   <= !sum_c[SUM_W-1];
				pend_sum_q   <= sum_c;
				pend_ft_q    <= cur_ft_q;
			end
			if (state_q == ST_R_EVAL && pend_valid_q) begin
				pend_valid_q <= 1'b0;
				if (pend_ft_q != '0) begin
					cur_pen_q <= miss ? miss_penalty : '0;
					hist_q[1] <= t_c;
					for (int i = 2; i < HIST_SLOTS; i++) hist_q[i] <= hist_q[i-1];
				end
			end
			if (state_q == ST_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			cur_kind_q <= q_req.kind;
			cur_addr_q <= q_req.address;
			cur_ft_q   <= q_req.fallthrough;
			cur_row_q  <= q_row;
		end
		if (state_q == ST_P_SUM) begin
			res_taken_q <= !sum_c[SUM_W-1];
			res_miss_q  <= 1'b0;
		end
		if (state_q == ST_R_EVAL) begin
			res_taken_q <= 1'b0;
			res_miss_q  <= pend_valid_q && (pend_ft_q != '0) && miss;
		end
		if (state_q == ST_OUT && out_free) begin
			m_data_q <= {(OUT_W-PEN_W-2)'(0), cur_pen_q, res_miss_q,
				res_taken_q && (cur_kind_q == REQ_PREDICT)};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/perceptron_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// perceptron_branch_predictor
// Perceptron branch predictor with a global direction history.
// ----------------------------------------------------------------------------
// A predict beat (tuser 0) picks weight row address mod ROWS and answers taken
// when bias plus the dot product of the row with the global history is
// non-negative; the branch then stays pending. A resolve beat (tuser 1) gives
// the actual next address: the branch was taken when it differs from the
// fall-through address. The result reports a miss and the penalty, trains the
// row when needed and shifts the outcome into the history. Every beat gives
// one result beat. After reset the weight store is cleared, one row per
// cycle, before the first request is served; register writes are taken
// throughout. A predict goes through row read, group sums, final sum and
// result in the execution side, a resolve through row read, train and
// write back, and result. The front takes the row from the low address bits
// when ROWS is a power of two and otherwise reduces four 16-bit address
// chunks, each a reciprocal multiply and a subtract with one correction;
// this overlaps the previous request through the two-entry request queue.
// ----------------------------------------------------------------------------
`default_nettype none

module perceptron_branch_predictor #(
	parameter int ROWS       = 256,
	parameter int HIST_SLOTS = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// request side
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [127:0]               s_tdata,   // [63:0] address, [127:64] fallthrough_pc
	input  wire logic [0:0]                 s_tuser,   // [0] req_type
	// result side
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [pbp_pkg::OUT_W-1:0]       m_tdata,   // [0] predicted_taken, [1] mispredicted,
	                                                   // [9:2] penalty, [15:10] zero
	// register writes
	input  wire logic                       cfg_we,
	input  wire logic [0:0]                 cfg_index,
	input  wire logic [pbp_pkg::CFG_W-1:0]  cfg_data
);
	import pbp_pkg::*;

	localparam int RB = $clog2(ROWS);
	localparam logic [THR_W-1:0] THR_RESET = THR_W'((193 * HIST_SLOTS + 1400) / 100);
	localparam logic [PEN_W-1:0] PEN_RESET = 8'd10;

	logic [PEN_W-1:0] miss_penalty_q;
	logic [THR_W-1:0] threshold_q;

	req_t          in_req;
	logic          q_valid, q_pop;
	req_t          q_req;
	logic [RB-1:0] q_row;

	// hold register values until rewritten
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_penalty_q <= PEN_RESET;
			threshold_q    <= THR_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MISS_PENALTY: miss_penalty_q <= cfg_data[PEN_W-1:0];
				CFG_THRESHOLD:    threshold_q    <= cfg_data[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_req.kind        = kind_t'(s_tuser[0]);
	assign in_req.address     = s_tdata[63:0];
	assign in_req.fallthrough = s_tdata[127:64];

	// front: accept beats, reduce the address to a row, queue
	pbp_front #(.ROWS(ROWS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_req  (in_req),
		.q_valid (q_valid),
		.q_req   (q_req),
		.q_row   (q_row),
		.q_pop   (q_pop)
	);

	// back: predict, resolve, train, drive the result beat
	pbp_back #(.ROWS(ROWS), .HIST_SLOTS(HIST_SLOTS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_req       (q_req),
		.q_row       (q_row),
		.q_pop       (q_pop),
		.miss_penalty(miss_penalty_q),
		.threshold   (threshold_q),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	// the back side never drops a request it has not been handed
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue popped while empty");

	// the front holds one beat at a time
	a_front_single: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready) else $error("front took two beats");

	// padding of the result beat stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_W-1:PEN_W+2] == '0)) else $error("result padding set");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the perceptron branch predictor.
// ----------------------------------------------------------------------------
// Drives predict and resolve beats with random gaps and result-side stalls.
// Every accepted request is run through a behavioral copy of the predictor,
// and the expected result beat is queued. Each result beat must match the
// oldest queued one, field by field. Register writes happen only while the
// block is idle, and the run covers several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import pbp_pkg::*;

	localparam int NROWS = 256;
	localparam int NSLOT = 32;
	localparam int WDOG  = 20000;

	typedef struct packed {
		logic       taken;
		logic       miss;
		logic [7:0] penalty;
	} branch_res_t;

	// Behavioral predictor plus the queue of expected results.
	class branch_scoreboard;
		int                 wgt [NROWS][NSLOT];
		int                 hist [NSLOT];
		bit                 pend_vld;
		int                 pend_row;
		bit                 pend_dir;
		int                 pend_sum;
		logic [63:0]        pend_ft;
		logic [7:0]         cur_pen;
		logic [7:0]         miss_pen;
		int                 thresh;
		branch_res_t        expq [$];
		int                 errors;

		function new();
			foreach (wgt[r, i]) wgt[r][i] = 0;
			foreach (hist[i]) hist[i] = 0;
			pend_vld = 0; pend_row = 0; pend_dir = 0; pend_sum = 0; pend_ft = '0;
			cur_pen = 0; miss_pen = 8'd10; thresh = 75; errors = 0;
		endfunction

		// Work out the result of one accepted request and queue it.
		function void note_request(kind_t kind, logic [63:0] addr, logic [63:0] ft);
			branch_res_t r;
			int          sum, t, n, mag;
			bit          outcome, miss;
			r = '0;
			if (kind == REQ_PREDICT) begin
				pend_row = int'(addr[7:0]);
				sum = wgt[pend_row][0];
				for (int i = 1; i < NSLOT; i++) sum += hist[i] * wgt[pend_row][i];
				pend_vld = 1;
				pend_dir = (sum >= 0);
				pend_sum = sum;
				pend_ft = ft;
				r.taken = pend_dir;
			end else if (pend_vld) begin
				if (pend_ft != 0) begin
					outcome = (addr != pend_ft);
					t = outcome ? 1 : -1;
					miss = (outcome != pend_dir);
					mag = pend_sum < 0 ? -pend_sum : pend_sum;
					cur_pen = miss ? miss_pen : 8'd0;
					r.miss = miss;
					if (miss || mag <= thresh) begin
						for (int i = 0; i < NSLOT; i++) begin
							n = wgt[pend_row][i] + t * (i == 0 ? 1 : hist[i]);
							// skip a step that would leave the weight range
							if (n <= 255 && n >= -256) wgt[pend_row][i] = n;
						end
					end
					for (int i = NSLOT - 1; i > 1; i--) hist[i] = hist[i - 1];
					hist[1] = t;
				end
				pend_vld = 0;
			end
			r.penalty = cur_pen;
			expq.push_back(r);
		endfunction

		task report_mismatch(string what, longint unsigned exp_v, longint unsigned got_v);
			errors++;
			$display("MISMATCH %s: expected %0h, got %0h", what, exp_v, got_v);
		endtask

		task check_result(logic [15:0] data);
			branch_res_t e;
			if (expq.size() == 0) begin
				report_mismatch("result beat with nothing expected", 0, data);
				return;
			end
			e = expq.pop_front();
			if (data[0] !== e.taken)
				report_mismatch("predicted_taken", e.taken, data[0]);
			if (data[1] !== e.miss)
				report_mismatch("mispredicted", e.miss, data[1]);
			if (data[9:2] !== e.penalty)
				report_mismatch("penalty", e.penalty, data[9:2]);
			if (data[15:10] !== 6'd0)
				report_mismatch("padding", 0, data[15:10]);
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [15:0]  m_tdata;
	logic         cfg_we;
	logic [0:0]   cfg_index;
	logic [12:0]  cfg_data;

	branch_scoreboard sb;
	int  idle_cycles;
	bit  hold_off;     // long receiver stall requested by the stimulus
	bit  stall_active; // receiver randomly stalls when set

	perceptron_branch_predictor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one, often none.
	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 50) return 0;
		if (p < 93) return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	// Check every result beat at the edge where it is accepted.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	// Receiver: random stalls, plus one long hold-off while requests pile up.
	initial begin
		int g;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			g = stall_active ? gap_len() : 0;
			if (hold_off) begin
				m_tready <= 0;
				repeat (200) @(posedge clk);
				hold_off = 0;
			end else if (g > 0) begin
				m_tready <= 0;
				repeat (g) @(posedge clk);
			end else begin
				m_tready <= 1;
				@(posedge clk);
			end
		end
	end

	// Watchdog: count cycles with no beat on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off)
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG) begin
				$display("perceptron_branch_predictor test failed");
				$finish;
			end
		end
	end

	// Offer one request beat and hold it until accepted; note it in the model.
	task automatic send_req(kind_t kind, logic [63:0] addr, logic [63:0] ft, bit gaps);
		int g;
		if (gaps) begin
			g = gap_len();
			if (g > 0) begin
				s_tvalid <= 0;
				repeat (g) @(posedge clk);
			end
		end
		s_tvalid <= 1;
		s_tuser  <= kind;
		s_tdata  <= {ft, addr};
		do @(posedge clk); while (!s_tready);
		sb.note_request(kind, addr, ft);
	endtask

	// Wait for every expected beat, then let the pipeline drain.
	task automatic drain();
		while (sb.expq.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [12:0] value);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
		if (idx == CFG_MISS_PENALTY) sb.miss_pen = value[7:0];
		else sb.thresh = value;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Predict/resolve pair with random direction and mostly non-zero fall-through.
	task automatic branch_pair(logic [63:0] pc, bit gaps);
		logic [63:0] ft, nxt;
		ft  = ($urandom_range(99) < 3) ? 64'd0 : pc + 64'd4;
		nxt = $urandom_range(1) ? ft : rand64();
		send_req(REQ_PREDICT, pc, ft, gaps);
		send_req(REQ_RESOLVE, nxt, rand64(), gaps);
	endtask

	initial begin
		logic [63:0] pcs [16];
		logic [63:0] pc;
		sb = new();
		idle_cycles = 0;
		hold_off = 0;
		stall_active = 0;
		arst_n    = 0;
		s_tvalid  = 0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_we    = 0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: resolve with nothing pending, field extremes, zero fall-through,
		// predict replacing a pending branch, taken and not-taken outcomes.
		send_req(REQ_RESOLVE, '1, '1, 0);
		send_req(REQ_PREDICT, '0, '1, 0);
		send_req(REQ_RESOLVE, '0, '0, 0);
		send_req(REQ_PREDICT, '1, '1, 0);
		send_req(REQ_RESOLVE, '1, '0, 0);
		send_req(REQ_PREDICT, 64'h10, 64'd0, 0);
		send_req(REQ_RESOLVE, 64'h55, '0, 0);
		send_req(REQ_PREDICT, 64'h20, 64'h24, 0);
		send_req(REQ_PREDICT, 64'h30, 64'h34, 0);
		send_req(REQ_RESOLVE, 64'h34, '1, 0);
		send_req(REQ_RESOLVE, 64'h34, '1, 0);
		for (int i = 0; i < 6; i++) begin
			send_req(REQ_PREDICT, 64'h40, 64'h44, 0);
			send_req(REQ_RESOLVE, (i % 2) ? 64'h44 : 64'h1000, '0, 0);
		end
		s_tvalid <= 0;
		drain();

		// Random phases, each with its own register setting; extremes included.
		stall_active = 1;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(CFG_MISS_PENALTY, 13'd255); write_reg(CFG_THRESHOLD, 13'd0); end
				1: begin write_reg(CFG_MISS_PENALTY, 13'd0); write_reg(CFG_THRESHOLD, 13'd8191); end
				2: begin write_reg(CFG_MISS_PENALTY, 13'd10); write_reg(CFG_THRESHOLD, 13'd75); end
				default: begin
					write_reg(CFG_MISS_PENALTY, 13'($urandom_range(255)));
					write_reg(CFG_THRESHOLD, 13'($urandom_range(300)));
				end
			endcase
			foreach (pcs[i]) pcs[i] = rand64();
			for (int n = 0; n < 170; n++) begin
				// Long receiver hold-off while requests keep coming.
				if (ph == 1 && n == 20) hold_off = 1;
				if ($urandom_range(99) < 85) begin
					// recurring branches so rows learn; gaps off in some stretches
					pc = pcs[$urandom_range(15)];
					branch_pair(pc, (n / 25) % 2 == 0);
				end else begin
					// noise: random kinds and addresses
					send_req(kind_t'($urandom_range(1)), rand64(), rand64(), 1);
				end
			end
			s_tvalid <= 0;
			while (hold_off) @(posedge clk);
			drain();
		end

		if (sb.errors == 0 && sb.expq.size() == 0)
			$display("perceptron_branch_predictor test passed");
		else
			$display("perceptron_branch_predictor test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/pbp_pkg.sv
hw/rtl/pbp_ram.sv
hw/rtl/pbp_front.sv
hw/rtl/pbp_back.sv
hw/rtl/perceptron_branch_predictor.sv
tb/testbench.sv
